/* rtl/assert_macros.svh */
// assertion macros used by k_way_sorted_merge
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  `ASSERT_CLK(lbl, clk, rstn, !(expr))
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/kwm_pkg.sv */
// types, constants and helpers for the k-way sorted merge block
// no dependencies
package kwm_pkg;

  localparam int NumLists  = 8;
  localparam int ListDepth = 64;
  localparam int ValW      = 32;
  localparam int LiW       = $clog2(NumLists);
  localparam int PtrW      = $clog2(ListDepth);
  localparam int CntW      = $clog2(ListDepth + 1);
  localparam int AddrW     = LiW + PtrW;
  localparam int MemDepth  = NumLists * ListDepth;
  localparam int LeafN     = 1 << LiW;
  localparam int NodeN     = 2 * LeafN - 1;

  localparam logic FuncAppend = 1'b0;
  localparam logic FuncPop    = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StOrder = 2'd3
  } status_e;

  typedef struct packed {
    logic                   func;
    logic [2:0]             list_index;
    logic signed [ValW-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [ValW-1:0] out_value;
    logic [2:0]             source_list;
    logic [1:0]             status;
  } out_rsp_t;

  typedef struct packed {
    logic           found;
    logic [LiW-1:0] idx;
  } min_sel_t;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    return (p == PtrW'(ListDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

endpackage

/* rtl/k_way_sorted_merge.sv */
// k-way sorted merge: per-list fifos in one memory, pop returns the smallest head
// the request is held in the input register and its result in the output register;
// a request waits while the output is stalled or the head refill of the pop before it runs
// appends are taken back to back unless the output stalls; a pop that leaves its list
// non-empty blocks the next request while the registered memory read refills its head
// reset: async active low, all lists empty, no memory clearing pass
// depends on kwm_pkg, kwm_min_tree, kwm_store, assert_macros.svh
`include "assert_macros.svh"
module k_way_sorted_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kwm_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kwm_pkg::out_rsp_t out_rsp_o
);

  logic                      in_valid_q, in_valid_d;
  kwm_pkg::in_req_t          in_q;
  logic                      out_valid_q, out_valid_d;
  kwm_pkg::out_rsp_t         out_q, out_d;
  logic                      refill_q, refill_d;
  logic [kwm_pkg::LiW-1:0]   refill_idx_q, refill_idx_d;

  logic [kwm_pkg::PtrW-1:0]        head_ptr_q [kwm_pkg::NumLists];
  logic [kwm_pkg::PtrW-1:0]        tail_ptr_q [kwm_pkg::NumLists];
  logic [kwm_pkg::CntW-1:0]        cnt_q      [kwm_pkg::NumLists];
  logic signed [kwm_pkg::ValW-1:0] tail_val_q [kwm_pkg::NumLists];
  logic signed [kwm_pkg::ValW-1:0] head_val_q [kwm_pkg::NumLists];

  logic [kwm_pkg::NumLists-1:0]    head_vld;
  kwm_pkg::min_sel_t               sel;
  logic                            proc_fire;
  logic                            is_pop;
  logic [kwm_pkg::LiW-1:0]         a_idx;
  logic                            a_full, a_order, append_ok, pop_ok, pop_refill;
  logic [kwm_pkg::PtrW-1:0]        pop_next;
  logic signed [kwm_pkg::ValW-1:0] rd_data;

  assign proc_fire  = in_valid_q && !refill_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;
  assign is_pop     = (in_q.func == kwm_pkg::FuncPop);
  assign a_idx      = in_q.list_index[kwm_pkg::LiW-1:0];
  assign a_full     = (32'(in_q.list_index) >= kwm_pkg::NumLists) ||
                      (cnt_q[a_idx] == kwm_pkg::CntW'(kwm_pkg::ListDepth));
  assign a_order    = (cnt_q[a_idx] != '0) && (in_q.value < tail_val_q[a_idx]);
  assign append_ok  = proc_fire && !is_pop && !a_full && !a_order;
  assign pop_ok     = proc_fire && is_pop && sel.found;
  assign pop_next   = kwm_pkg::next_slot(head_ptr_q[sel.idx]);
  assign pop_refill = pop_ok && (cnt_q[sel.idx] > kwm_pkg::CntW'(1));

  always_comb begin
    for (int i = 0; i < kwm_pkg::NumLists; i++) begin
      head_vld[i] = (cnt_q[i] != '0);
    end
  end

  kwm_min_tree u_min_tree (
    .head_val_i (head_val_q),
    .head_vld_i (head_vld),
    .sel_o      (sel)
  );

  kwm_store u_store (
    .clk_i   (clk_i),
    .we_i    (append_ok),
    .waddr_i ({a_idx, tail_ptr_q[a_idx]}),
    .wdata_i (in_q.value),
    .re_i    (pop_refill),
    .raddr_i ({sel.idx, pop_next}),
    .rdata_o (rd_data)
  );

  // result of the request in the input register
  always_comb begin
    out_d = '0;
    if (is_pop) begin
      if (sel.found) begin
        out_d.out_value   = head_val_q[sel.idx];
        out_d.source_list = 3'(sel.idx);
        out_d.status      = kwm_pkg::StOk;
      end else begin
        out_d.status = kwm_pkg::StEmpty;
      end
    end else if (a_full) begin
      out_d.status = kwm_pkg::StFull;
    end else if (a_order) begin
      out_d.status = kwm_pkg::StOrder;
    end else begin
      out_d.status = kwm_pkg::StOk;
    end
  end

  always_comb begin
    in_valid_d   = in_valid_q;
    out_valid_d  = out_valid_q;
    refill_d     = pop_refill;
    refill_idx_d = pop_refill ? sel.idx : refill_idx_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (proc_fire) begin
      in_valid_d = 1'b0;
    end
    if (proc_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      refill_q     <= 1'b0;
      refill_idx_q <= '0;
      for (int i = 0; i < kwm_pkg::NumLists; i++) begin
        head_ptr_q[i] <= '0;
        tail_ptr_q[i] <= '0;
        cnt_q[i]      <= '0;
      end
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      refill_q     <= refill_d;
      refill_idx_q <= refill_idx_d;
      if (append_ok) begin
        tail_ptr_q[a_idx] <= kwm_pkg::next_slot(tail_ptr_q[a_idx]);
        cnt_q[a_idx]      <= cnt_q[a_idx] + kwm_pkg::CntW'(1);
      end
      if (pop_ok) begin
        head_ptr_q[sel.idx] <= pop_next;
        cnt_q[sel.idx]      <= cnt_q[sel.idx] - kwm_pkg::CntW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
    if (proc_fire) begin
      out_q <= out_d;
    end
    if (append_ok) begin
      tail_val_q[a_idx] <= in_q.value;
      if (cnt_q[a_idx] == '0) begin
        head_val_q[a_idx] <= in_q.value;
      end
    end
    if (refill_q) begin
      head_val_q[refill_idx_q] <= rd_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `ASSERT_NEVER(a_no_proc_in_refill, clk_i, rst_ni, refill_q && proc_fire)
  `ASSERT_CLK(a_refill_one_cycle, clk_i, rst_ni, refill_q |=> !refill_q)
  `ASSERT_CLK(a_pop_sets_refill, clk_i, rst_ni, pop_refill |=> refill_q && (refill_idx_q == $past(sel.idx)))
  `ASSERT_CLK(a_empty_append_head, clk_i, rst_ni, (append_ok && cnt_q[a_idx] == '0) |=> (head_val_q[$past(a_idx)] == $past(in_q.value)))

endmodule

/* rtl/kwm_store.sv */
// element memory holding all lists, one write and one registered read per cycle
// depends on kwm_pkg
module kwm_store (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [kwm_pkg::AddrW-1:0]           waddr_i,
  input  logic signed [kwm_pkg::ValW-1:0]     wdata_i,
  input  logic                                re_i,
  input  logic [kwm_pkg::AddrW-1:0]           raddr_i,
  output logic signed [kwm_pkg::ValW-1:0]     rdata_o
);

  logic signed [kwm_pkg::ValW-1:0] mem_q [kwm_pkg::MemDepth];
  logic signed [kwm_pkg::ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kwm_min_tree.sv */
// compare tree picking the smallest valid head, lower list wins on ties
// depends on kwm_pkg
module kwm_min_tree (
  input  logic signed [kwm_pkg::ValW-1:0] head_val_i [kwm_pkg::NumLists],
  input  logic [kwm_pkg::NumLists-1:0]    head_vld_i,
  output kwm_pkg::min_sel_t               sel_o
);

  logic                            vld [kwm_pkg::NodeN];
  logic signed [kwm_pkg::ValW-1:0] val [kwm_pkg::NodeN];
  logic [kwm_pkg::LiW-1:0]         idx [kwm_pkg::NodeN];

  always_comb begin
    for (int n = 0; n < kwm_pkg::NodeN; n++) begin
      vld[n] = 1'b0;
      val[n] = '0;
      idx[n] = '0;
    end
    for (int i = 0; i < kwm_pkg::LeafN; i++) begin
      if (i < kwm_pkg::NumLists) begin
        vld[kwm_pkg::LeafN - 1 + i] = head_vld_i[i];
        val[kwm_pkg::LeafN - 1 + i] = head_val_i[i];
      end
      idx[kwm_pkg::LeafN - 1 + i] = kwm_pkg::LiW'(i);
    end
    for (int n = kwm_pkg::LeafN - 2; n >= 0; n--) begin
      if (vld[2*n+1] && (!vld[2*n+2] || val[2*n+1] <= val[2*n+2])) begin
        val[n] = val[2*n+1];
        idx[n] = idx[2*n+1];
      end else begin
        val[n] = val[2*n+2];
        idx[n] = idx[2*n+2];
      end
      vld[n] = vld[2*n+1] | vld[2*n+2];
    end
  end

  assign sel_o.found = vld[0];
  assign sel_o.idx   = idx[0];

endmodule

/* tb/sv/tb_k_way_sorted_merge.sv */
// self-checking testbench for k_way_sorted_merge: directed and random append/pop
// requests, checked field by field against an in-bench model of the list fifos
// depends on kwm_pkg and the k_way_sorted_merge rtl
module tb_k_way_sorted_merge;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumItems   = 850;
  localparam int QuietLimit = 4000;
  localparam int ValMax     = 2147483647;
  localparam longint ValMin = -64'sd2147483648;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  kwm_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  kwm_pkg::out_rsp_t out_rsp;

  k_way_sorted_merge DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  kwm_pkg::in_req_t  pending_requests[$];
  kwm_pkg::out_rsp_t awaited_outcomes[$];
  int                total_requests = 0;
  int                n_sent = 0;
  int                n_results = 0;
  int                n_errors = 0;
  int                quiet_cycles = 0;

  // list fifo state as the block should hold it
  logic signed [kwm_pkg::ValW-1:0] list_mem [kwm_pkg::NumLists][kwm_pkg::ListDepth];
  logic [kwm_pkg::PtrW-1:0]        head_slot [kwm_pkg::NumLists];
  logic [kwm_pkg::PtrW-1:0]        tail_slot [kwm_pkg::NumLists];
  logic [kwm_pkg::CntW-1:0]        held [kwm_pkg::NumLists];
  logic signed [kwm_pkg::ValW-1:0] last_kept [kwm_pkg::NumLists];

  // stimulus-side guess of each list's tail, used to build rising sequences
  longint gen_tail [kwm_pkg::NumLists];
  bit     gen_live [kwm_pkg::NumLists];

  initial begin
    for (int i = 0; i < kwm_pkg::NumLists; i++) begin
      head_slot[i] = '0;
      tail_slot[i] = '0;
      held[i]      = '0;
      last_kept[i] = '0;
      gen_tail[i]  = 0;
      gen_live[i]  = 1'b0;
    end
  end

  function automatic logic [kwm_pkg::PtrW-1:0] wrap_inc(logic [kwm_pkg::PtrW-1:0] p);
    return (p == kwm_pkg::PtrW'(kwm_pkg::ListDepth - 1)) ? '0 : p + kwm_pkg::PtrW'(1);
  endfunction

  function automatic kwm_pkg::out_rsp_t merge_outcome(kwm_pkg::in_req_t req);
    kwm_pkg::out_rsp_t               r;
    int                              best;
    logic signed [kwm_pkg::ValW-1:0] best_val;
    logic [kwm_pkg::LiW-1:0]         li;
    r        = '0;
    r.status = kwm_pkg::StOk;
    best     = -1;
    best_val = '0;
    li       = req.list_index;
    if (req.func == kwm_pkg::FuncAppend) begin
      if (held[li] >= kwm_pkg::ListDepth) begin
        r.status = kwm_pkg::StFull;
      end else if (held[li] != 0 && req.value < last_kept[li]) begin
        r.status = kwm_pkg::StOrder;
      end else begin
        list_mem[li][tail_slot[li]] = req.value;
        tail_slot[li] = wrap_inc(tail_slot[li]);
        last_kept[li] = req.value;
        held[li]      = held[li] + 1'b1;
      end
    end else begin
      for (int i = 0; i < kwm_pkg::NumLists; i++) begin
        if (held[i] != 0 && (best < 0 || list_mem[i][head_slot[i]] < best_val)) begin
          best     = i;
          best_val = list_mem[i][head_slot[i]];
        end
      end
      if (best < 0) begin
        r.status = kwm_pkg::StEmpty;
      end else begin
        r.out_value   = best_val;
        r.source_list = 3'(best);
        head_slot[best] = wrap_inc(head_slot[best]);
        held[best]      = held[best] - 1'b1;
      end
    end
    return r;
  endfunction

  // sender idles 31 then 88 then 0 percent; receiver 88 then 31 then 0
  function automatic int idle_pct(bit sender, int done);
    int third;
    third = (total_requests == 0) ? 1 : total_requests / 3;
    if (done < third) return sender ? 31 : 88;
    if (done < 2 * third) return sender ? 88 : 31;
    return 0;
  endfunction

  task automatic add_append(int li, logic signed [kwm_pkg::ValW-1:0] v);
    kwm_pkg::in_req_t r;
    r.func       = kwm_pkg::FuncAppend;
    r.list_index = 3'(li);
    r.value      = v;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic add_pop();
    kwm_pkg::in_req_t r;
    r.func       = kwm_pkg::FuncPop;
    r.list_index = 3'($urandom_range(kwm_pkg::NumLists - 1));
    r.value      = $urandom;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  function automatic logic signed [kwm_pkg::ValW-1:0] rising_value(int li);
    longint v;
    int     pick;
    pick = $urandom_range(99);
    if (!gen_live[li]) v = longint'($signed($urandom));
    else if (pick < 10) v = gen_tail[li];
    else if (pick < 75) v = gen_tail[li] + $urandom_range(50, 1);
    else v = gen_tail[li] + $urandom_range(1 << 24, 1);
    if (v > ValMax) v = ValMax;
    gen_live[li] = 1'b1;
    gen_tail[li] = v;
    return v[kwm_pkg::ValW-1:0];
  endfunction

  function automatic logic signed [kwm_pkg::ValW-1:0] falling_value(int li);
    longint v;
    v = gen_tail[li] - $urandom_range(100, 1);
    if (v < ValMin) v = ValMin;
    return v[kwm_pkg::ValW-1:0];
  endfunction

  task automatic build_random();
    int mode;
    int n;
    int li;
    while (pending_requests.size() < NumItems) begin
      mode = $urandom_range(99);
      n    = $urandom_range(20, 2);
      if (mode < 38) begin
        for (int k = 0; k < n; k++) begin
          li = $urandom_range(kwm_pkg::NumLists - 1);
          if (gen_live[li] && $urandom_range(99) < 8) add_append(li, falling_value(li));
          else add_append(li, rising_value(li));
        end
      end else if (mode < 63) begin
        for (int k = 0; k < n; k++) add_pop();
        if ($urandom_range(1) == 1) begin
          for (int i = 0; i < kwm_pkg::NumLists; i++) gen_live[i] = 1'b0;
        end
      end else if (mode < 83) begin
        for (int k = 0; k < n; k++) begin
          li = $urandom_range(kwm_pkg::NumLists - 1);
          if ($urandom_range(1) == 1) add_pop();
          else add_append(li, rising_value(li));
        end
      end else if (mode < 95) begin
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(1) == 1) add_pop();
          else add_append($urandom_range(kwm_pkg::NumLists - 1), $urandom);
        end
      end else begin
        li = $urandom_range(kwm_pkg::NumLists - 1);
        for (int k = 0; k < kwm_pkg::ListDepth + 2; k++) add_append(li, rising_value(li));
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic             nxt_valid;
    kwm_pkg::in_req_t nxt_req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_req   = in_req;
      if (in_valid && in_ready) begin
        awaited_outcomes.insert(awaited_outcomes.size(), merge_outcome(in_req));
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_requests.size() != 0 &&
          $urandom_range(99) >= idle_pct(1'b1, n_sent)) begin
        nxt_valid = 1'b1;
        nxt_req   = pending_requests.pop_front();
      end
      in_valid <= nxt_valid;
      in_req   <= nxt_req;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch
    kwm_pkg::out_rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding", n_results));
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_rsp.out_value !== want.out_value)
            report_mismatch($sformatf("result %0d out_value %0d, want %0d",
                                      n_results, out_rsp.out_value, want.out_value));
          if (out_rsp.source_list !== want.source_list)
            report_mismatch($sformatf("result %0d source_list %0d, want %0d",
                                      n_results, out_rsp.source_list, want.source_list));
          if (out_rsp.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      n_results, out_rsp.status, want.status));
        end
        n_results++;
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0, n_results));
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("tb_k_way_sorted_merge: errors");
    $finish;
  end

  initial begin
    // empty pop, extremes, ties, order reject, equal accept
    add_pop();
    add_append(0, 32'sh8000_0000);
    add_append(7, 32'sh7fff_ffff);
    add_append(3, 32'sd5);
    add_append(1, 32'sd5);
    add_append(3, 32'sd4);
    add_append(3, 32'sd5);
    add_append(7, 32'sh7fff_fffe);
    for (int k = 0; k < 7; k++) add_pop();
    // empty list takes a value below its old tail
    add_append(2, 32'sd100);
    add_pop();
    add_append(2, -32'sd100);
    add_append(6, 32'sh5555_aaaa);
    add_append(5, -32'sd1);
    add_append(6, 32'sh0000_0000);
    add_pop();
    add_pop();
    add_pop();
    // one list to full, overflow, then drained
    for (int k = 0; k < kwm_pkg::ListDepth + 2; k++) add_append(4, rising_value(4));
    for (int k = 0; k < kwm_pkg::ListDepth + 1; k++) add_pop();
    gen_live[4] = 1'b0;
    build_random();
    total_requests = pending_requests.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(n_sent == total_requests && awaited_outcomes.size() == 0)) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (n_errors == 0) $display("tb_k_way_sorted_merge: clean");
    else $display("tb_k_way_sorted_merge: errors");
    $finish;
  end

endmodule

/* k_way_sorted_merge.f */
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_store.sv
rtl/kwm_min_tree.sv
rtl/k_way_sorted_merge.sv
tb/sv/tb_k_way_sorted_merge.sv
